[rtl/nft_pkg.sv]
// Shared types and constants of the noise floor tracker.
package nft_pkg;

  localparam int unsigned LevelW = 16;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned CountW = 7;
  localparam int unsigned AccW   = 32;

  localparam logic [AlphaW-1:0] QOne = 17'h10000;

  localparam logic [LevelW-1:0] MinFloorRst = 16'd0;
  localparam logic [LevelW-1:0] MaxFloorRst = 16'd65535;
  localparam logic [LevelW-1:0] SeedFloorRst = 16'd328;
  localparam logic [AlphaW-1:0] AlphaRst = 17'd655;
  localparam logic [CountW-1:0] CalCountRst = 7'd32;

  typedef enum logic {
    FUNC_OBSERVE = 1'b0,
    FUNC_RESTART = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    CFG_MIN_FLOOR = 3'd0,
    CFG_MAX_FLOOR = 3'd1,
    CFG_SEED_FLOOR = 3'd2,
    CFG_EMA_ALPHA = 3'd3,
    CFG_CAL_COUNT = 3'd4
  } cfg_idx_e;

  // Status of the median selection unit toward the sequencer.
  typedef struct packed {
    logic              done;
    logic [LevelW-1:0] median;
  } sel_res_t;

endpackage

[rtl/nft_store.sv]
// Frame store: one write port and two registered read ports.
module nft_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [nft_pkg::LevelW-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_a_i,
  input  logic [AW-1:0]             raddr_b_i,
  output logic [nft_pkg::LevelW-1:0] rdata_a_o,
  output logic [nft_pkg::LevelW-1:0] rdata_b_o
);
  import nft_pkg::*;

  logic [LevelW-1:0] mem_q [DEPTH];
  logic [LevelW-1:0] rdata_a_q;
  logic [LevelW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/nft_select.sv]
// Median selection by rank counting with one shared comparator.
module nft_select #(
  parameter int unsigned AW    = 6,
  parameter int unsigned CNT_W = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [CNT_W-1:0]           n_i,
  output logic [AW-1:0]              raddr_a_o,
  output logic [AW-1:0]              raddr_b_o,
  input  logic [nft_pkg::LevelW-1:0] rdata_a_i,
  input  logic [nft_pkg::LevelW-1:0] rdata_b_i,
  output nft_pkg::sel_res_t          res_o
);
  import nft_pkg::*;

  typedef enum logic [1:0] {
    SL_IDLE,
    SL_SCAN,
    SL_DECIDE
  } sl_state_e;

  sl_state_e         state_q, state_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [CNT_W-1:0]  lt_q, lt_d;
  logic [CNT_W-1:0]  le_q, le_d;
  logic              cmp_v_q, cmp_v_d;
  logic              cmp_last_q, cmp_last_d;
  logic [LevelW-1:0] lo_q, lo_d;
  logic [LevelW-1:0] hi_q, hi_d;
  logic              done_q, done_d;
  logic [LevelW-1:0] med_q, med_d;

  logic              issue;
  logic [LevelW:0]   diff;
  logic              b_lt;
  logic              b_le;
  logic [CNT_W-1:0]  k_hi;
  logic [CNT_W-1:0]  k_lo;
  logic [LevelW:0]   mid_sum;

  assign raddr_a_o = i_q[AW-1:0];
  assign raddr_b_o = j_q[AW-1:0];

  // One subtract serves both the less-than and the equal test.
  assign diff = {1'b0, rdata_b_i} - {1'b0, rdata_a_i};
  assign b_lt = diff[LevelW];
  assign b_le = b_lt | (diff[LevelW-1:0] == '0);

  assign issue = (state_q == SL_SCAN) && (j_q != n_q);
  assign k_hi  = n_q >> 1;
  assign k_lo  = k_hi - CNT_W'(1);

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    i_d        = i_q;
    j_d        = j_q;
    lt_d       = lt_q;
    le_d       = le_q;
    cmp_v_d    = issue;
    cmp_last_d = issue && (j_q == n_q - CNT_W'(1));
    lo_d       = lo_q;
    hi_d       = hi_q;
    done_d     = 1'b0;
    med_d      = med_q;
    mid_sum    = '0;

    if (issue) begin
      j_d = j_q + CNT_W'(1);
    end
    if (cmp_v_q) begin
      lt_d = lt_q + CNT_W'(b_lt);
      le_d = le_q + CNT_W'(b_le);
    end

    case (state_q)
      SL_IDLE: begin
        if (start_i) begin
          n_d     = n_i;
          i_d     = '0;
          j_d     = '0;
          lt_d    = '0;
          le_d    = '0;
          state_d = SL_SCAN;
        end
      end
      SL_SCAN: begin
        if (cmp_v_q && cmp_last_q) begin
          state_d = SL_DECIDE;
        end
      end
      SL_DECIDE: begin
        // The candidate is the element of rank k when k lies in [lt, le).
        if ((lt_q <= k_hi) && (k_hi < le_q)) begin
          hi_d = rdata_a_i;
        end
        if (!n_q[0] && (lt_q <= k_lo) && (k_lo < le_q)) begin
          lo_d = rdata_a_i;
        end
        lt_d = '0;
        le_d = '0;
        j_d  = '0;
        if (i_q == n_q - CNT_W'(1)) begin
          mid_sum = {1'b0, lo_d} + {1'b0, hi_d};
          med_d   = n_q[0] ? hi_d : mid_sum[LevelW:1];
          done_d  = 1'b1;
          state_d = SL_IDLE;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = SL_SCAN;
        end
      end
      default: state_d = SL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SL_IDLE;
      n_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      lt_q       <= '0;
      le_q       <= '0;
      cmp_v_q    <= 1'b0;
      cmp_last_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      i_q        <= i_d;
      j_q        <= j_d;
      lt_q       <= lt_d;
      le_q       <= le_d;
      cmp_v_q    <= cmp_v_d;
      cmp_last_q <= cmp_last_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    med_q <= med_d;
  end

  assign res_o.done   = done_q;
  assign res_o.median = med_q;

endmodule

[rtl/noise_floor_tracker_top.sv]
// Noise floor tracker: frame store, median calibration and EMA tracking.
// A restart, a speech frame or a gathered frame goes straight to ST_DONE; an EMA update
// steps through ST_MUL0, ST_MUL1 and ST_EMA first; a calibration waits in ST_SEL for the
// median of the n stored frames, found with the single comparator and the store's read ports.
// Throughput: one item at a time; in_stall_o stays high until its result is registered.
// Reset: floor 328, uncalibrated, store empty, registers at their reset values.
module noise_floor_tracker_top #(
  parameter int unsigned CAL_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [15:0] frame_rms_i,
  input  logic        speech_active_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] noise_floor_o,
  output logic        is_calibrated_o
);
  import nft_pkg::*;

  localparam int unsigned AW    = (CAL_DEPTH > 1) ? $clog2(CAL_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CAL_DEPTH + 1);
  localparam int unsigned TW    = (CNT_W > CountW) ? CNT_W : CountW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL0,
    ST_MUL1,
    ST_EMA,
    ST_DONE
  } st_e;

  function automatic logic [LevelW-1:0] limit_floor(input logic [LevelW-1:0] v,
                                                    input logic [LevelW-1:0] lo,
                                                    input logic [LevelW-1:0] hi);
    logic [LevelW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [LevelW-1:0] min_floor_q;
  logic [LevelW-1:0] max_floor_q;
  logic [LevelW-1:0] seed_floor_q;
  logic [AlphaW-1:0] alpha_q;
  logic [CountW-1:0] cal_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_floor_q  <= MinFloorRst;
      max_floor_q  <= MaxFloorRst;
      seed_floor_q <= SeedFloorRst;
      alpha_q      <= AlphaRst;
      cal_count_q  <= CalCountRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_FLOOR:  min_floor_q  <= cfg_wdata_i[LevelW-1:0];
        CFG_MAX_FLOOR:  max_floor_q  <= cfg_wdata_i[LevelW-1:0];
        CFG_SEED_FLOOR: seed_floor_q <= cfg_wdata_i[LevelW-1:0];
        CFG_EMA_ALPHA:  alpha_q      <= cfg_wdata_i;
        CFG_CAL_COUNT:  cal_count_q  <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  st_e               state_q, state_d;
  logic [LevelW-1:0] floor_q, floor_d;
  logic              cal_q, cal_d;
  logic [CNT_W-1:0]  stored_q, stored_d;
  logic [LevelW-1:0] rms_q, rms_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  logic [LevelW-1:0] out_floor_q, out_floor_d;
  logic              out_cal_q, out_cal_d;

  logic              in_beat;
  logic [CNT_W-1:0]  stored_inc;
  logic [TW-1:0]     target;
  logic [AlphaW-1:0] alpha_sat;
  logic [AlphaW-1:0] mul_a;
  logic [LevelW-1:0] mul_b;
  logic [AlphaW+LevelW-1:0] mul_p;
  logic              st_we;
  logic              sel_start;
  logic [AW-1:0]     raddr_a;
  logic [AW-1:0]     raddr_b;
  logic [LevelW-1:0] rdata_a;
  logic [LevelW-1:0] rdata_b;
  sel_res_t          sel_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;

  assign stored_inc = stored_q + CNT_W'(stored_q < CNT_W'(CAL_DEPTH));
  assign target     = (TW'(cal_count_q) > TW'(CAL_DEPTH)) ? TW'(CAL_DEPTH) : TW'(cal_count_q);
  assign alpha_sat  = (alpha_q > QOne) ? QOne : alpha_q;

  assign st_we = in_beat && (func_i == FUNC_OBSERVE) && !speech_active_i && !cal_q &&
                 (stored_q < CNT_W'(CAL_DEPTH));
  assign sel_start = st_we && (TW'(stored_inc) >= target) ||
                     in_beat && (func_i == FUNC_OBSERVE) && !speech_active_i && !cal_q &&
                     (TW'(stored_inc) >= target);

  // Shared multiplier: weight of the old floor first, then of the new frame.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL0: begin
        mul_a = QOne - alpha_sat;
        mul_b = floor_q;
      end
      ST_MUL1: begin
        mul_a = alpha_sat;
        mul_b = rms_q;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d     = state_q;
    floor_d     = floor_q;
    cal_d       = cal_q;
    stored_d    = stored_q;
    rms_d       = rms_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_floor_d = out_floor_q;
    out_cal_d   = out_cal_q;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          rms_d   = frame_rms_i;
          state_d = ST_DONE;
          if (func_i == FUNC_RESTART) begin
            floor_d  = limit_floor(seed_floor_q, min_floor_q, max_floor_q);
            cal_d    = 1'b0;
            stored_d = '0;
          end else if (!speech_active_i) begin
            if (!cal_q) begin
              stored_d = stored_inc;
              if (sel_start) begin
                state_d = ST_SEL;
              end
            end else begin
              state_d = ST_MUL0;
            end
          end
        end
      end
      ST_SEL: begin
        if (sel_res.done) begin
          floor_d  = limit_floor(sel_res.median, min_floor_q, max_floor_q);
          cal_d    = 1'b1;
          stored_d = '0;
          state_d  = ST_DONE;
        end
      end
      ST_MUL0: begin
        acc_d   = mul_p[AccW-1:0];
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        acc_d   = acc_q + mul_p[AccW-1:0];
        state_d = ST_EMA;
      end
      ST_EMA: begin
        floor_d = limit_floor(acc_q[AccW-1:LevelW], min_floor_q, max_floor_q);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_floor_d = floor_q;
          out_cal_d   = cal_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      floor_q     <= SeedFloorRst;
      cal_q       <= 1'b0;
      stored_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      floor_q     <= floor_d;
      cal_q       <= cal_d;
      stored_q    <= stored_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rms_q       <= rms_d;
    acc_q       <= acc_d;
    out_floor_q <= out_floor_d;
    out_cal_q   <= out_cal_d;
  end

  nft_store #(
    .DEPTH(CAL_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (st_we),
    .waddr_i  (stored_q[AW-1:0]),
    .wdata_i  (frame_rms_i),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  nft_select #(
    .AW   (AW),
    .CNT_W(CNT_W)
  ) u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sel_start),
    .n_i      (stored_inc),
    .raddr_a_o(raddr_a),
    .raddr_b_o(raddr_b),
    .rdata_a_i(rdata_a),
    .rdata_b_i(rdata_b),
    .res_o    (sel_res)
  );

  assign out_valid_o     = out_valid_q;
  assign noise_floor_o   = out_floor_q;
  assign is_calibrated_o = out_cal_q;

  a_restart_clears_cal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (func_i == FUNC_RESTART) |=> !cal_q && (stored_q == '0))
    else $error("restart did not clear calibration");

  a_stored_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CNT_W'(CAL_DEPTH))
    else $error("stored frame count beyond store depth");

  a_sel_done_in_sel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_res.done |-> (state_q == ST_SEL))
    else $error("median result outside calibration");

  a_cal_store_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_q |-> (stored_q == '0))
    else $error("frames held while calibrated");

endmodule

[sim/noise_floor_tracker_top_tb.sv]
// Self-checking testbench of the noise floor tracker: directed cases, back-pressure, random phases.
`timescale 1ns / 1ps

module noise_floor_tracker_top_tb;
  import nft_pkg::*;

  localparam int unsigned StoreDepth  = 64;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 400000;

  typedef struct packed {
    logic [LevelW-1:0] noise_floor;
    logic              is_calibrated;
  } floor_report_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [2:0]        cfg_index_i;
  logic [AlphaW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              func_i;
  logic [LevelW-1:0] frame_rms_i;
  logic              speech_active_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [LevelW-1:0] noise_floor_o;
  logic              is_calibrated_o;

  // Shadow copy of the register file.
  logic [LevelW-1:0] min_floor_q;
  logic [LevelW-1:0] max_floor_q;
  logic [LevelW-1:0] seed_floor_q;
  logic [AlphaW-1:0] ema_alpha_q;
  logic [CountW-1:0] cal_count_q;

  // Tracker state as the testbench sees it.
  logic [LevelW-1:0] frame_store [StoreDepth];
  int unsigned       frames_held;
  logic [LevelW-1:0] floor_est;
  logic              calibrated;

  floor_report_t pending_reports [$];
  int unsigned   fail_count;
  int unsigned   items_sent;
  int unsigned   restarts_seen;
  int unsigned   calibrations_seen;
  int unsigned   ema_updates;
  int unsigned   speech_skipped;
  int unsigned   hold_requests;
  int unsigned   hold_served;
  bit            calm;

  noise_floor_tracker_top #(
    .CAL_DEPTH(StoreDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .frame_rms_i    (frame_rms_i),
    .speech_active_i(speech_active_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .noise_floor_o  (noise_floor_o),
    .is_calibrated_o(is_calibrated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [LevelW-1:0] clamp_level(logic [31:0] level);
    if (level < 32'(min_floor_q)) return min_floor_q;
    if (level > 32'(max_floor_q)) return max_floor_q;
    return level[LevelW-1:0];
  endfunction

  function automatic logic [LevelW-1:0] pick_level();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return LevelW'($urandom_range(65535));
    endcase
  endfunction

  // Advances the tracker by one accepted beat and returns the report it should produce.
  function automatic floor_report_t step_tracker(func_e op, logic [LevelW-1:0] rms,
                                                 logic speech);
    logic [LevelW-1:0] sorted [StoreDepth];
    logic [LevelW-1:0] key;
    int unsigned       target;
    int unsigned       mid;
    int unsigned       j;
    longint unsigned   weight;
    longint unsigned   acc;
    if (op == FUNC_RESTART) begin
      frames_held = 0;
      floor_est = clamp_level(32'(seed_floor_q));
      calibrated = 1'b0;
      restarts_seen++;
    end else if (speech) begin
      speech_skipped++;
    end else if (!calibrated) begin
      target = (cal_count_q > StoreDepth) ? StoreDepth : cal_count_q;
      if (frames_held < StoreDepth) begin
        frame_store[frames_held] = rms;
        frames_held++;
      end
      if (frames_held >= target) begin
        for (int i = 0; i < frames_held; i++) begin
          key = frame_store[i];
          j = i;
          while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = key;
        end
        mid = frames_held / 2;
        // An even count takes the truncated mean of the middle pair.
        if (frames_held % 2 == 1) begin
          floor_est = clamp_level(32'(sorted[mid]));
        end else begin
          floor_est = clamp_level((32'(sorted[mid-1]) + 32'(sorted[mid])) >> 1);
        end
        calibrated = 1'b1;
        frames_held = 0;
        calibrations_seen++;
      end
    end else begin
      weight = (ema_alpha_q > QOne) ? 64'(QOne) : 64'(ema_alpha_q);
      acc = (64'(QOne) - weight) * 64'(floor_est) + weight * 64'(rms);
      floor_est = clamp_level(32'(acc >> 16));
      ema_updates++;
    end
    return '{noise_floor: floor_est, is_calibrated: calibrated};
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [AlphaW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_MIN_FLOOR:  min_floor_q  = value[LevelW-1:0];
      CFG_MAX_FLOOR:  max_floor_q  = value[LevelW-1:0];
      CFG_SEED_FLOOR: seed_floor_q = value[LevelW-1:0];
      CFG_EMA_ALPHA:  ema_alpha_q  = value;
      CFG_CAL_COUNT:  cal_count_q  = value[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [LevelW-1:0] lo, logic [LevelW-1:0] hi,
                              logic [LevelW-1:0] seed, logic [AlphaW-1:0] alpha,
                              logic [CountW-1:0] count);
    write_reg(CFG_MIN_FLOOR, AlphaW'(lo));
    write_reg(CFG_MAX_FLOOR, AlphaW'(hi));
    write_reg(CFG_SEED_FLOOR, AlphaW'(seed));
    write_reg(CFG_EMA_ALPHA, alpha);
    write_reg(CFG_CAL_COUNT, AlphaW'(count));
    cfg_we_i <= 1'b0;
  endtask

  // Offers one beat after a random idle gap and returns at the edge that accepts it.
  task automatic send_item(func_e op, logic [LevelW-1:0] rms, logic speech);
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 29) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= op;
    frame_rms_i     <= rms;
    speech_active_i <= speech;
    do @(posedge clk_i); while (in_stall_o);
    pending_reports = {pending_reports, step_tracker(op, rms, speech)};
    items_sent++;
  endtask

  // Always advances at least one edge, so a following beat never re-drives valid in this step.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
  endtask

  task automatic test_reset_state();
    send_item(FUNC_OBSERVE, 16'hFFFF, 1'b1);
    send_item(FUNC_RESTART, 16'hFFFF, 1'b1);
    send_item(FUNC_OBSERVE, 16'h0000, 1'b0);
  endtask

  task automatic test_single_frame_unity_alpha();
    drain_results();
    program_regs(16'h0000, 16'hFFFF, 16'h0000, QOne, 7'd1);
    send_item(FUNC_RESTART, 16'h0000, 1'b0);
    send_item(FUNC_OBSERVE, 16'hFFFF, 1'b0);
    send_item(FUNC_OBSERVE, 16'h0000, 1'b0);
    send_item(FUNC_OBSERVE, 16'hFFFF, 1'b0);
  endtask

  // Alpha beyond one acts as one, a count of zero acts as one, the seed is clamped.
  task automatic test_alpha_above_one_and_limits();
    drain_results();
    program_regs(16'd100, 16'd200, 16'hFFFF, '1, 7'd0);
    send_item(FUNC_RESTART, 16'h0000, 1'b0);
    send_item(FUNC_OBSERVE, 16'h0000, 1'b0);
    send_item(FUNC_OBSERVE, 16'hFFFF, 1'b0);
    send_item(FUNC_OBSERVE, 16'h0000, 1'b1);
  endtask

  task automatic test_even_median_alpha_zero();
    drain_results();
    program_regs(16'h0000, 16'hFFFF, SeedFloorRst, '0, 7'd2);
    send_item(FUNC_RESTART, 16'hFFFF, 1'b0);
    send_item(FUNC_OBSERVE, 16'hFFFF, 1'b0);
    send_item(FUNC_OBSERVE, 16'hFFFE, 1'b0);
    send_item(FUNC_OBSERVE, 16'h0000, 1'b0);
  endtask

  task automatic test_crossed_limits();
    drain_results();
    program_regs(16'd1000, 16'd500, 16'd700, AlphaRst, 7'd3);
    send_item(FUNC_RESTART, 16'h0000, 1'b0);
    send_item(FUNC_OBSERVE, 16'd3, 1'b0);
    send_item(FUNC_OBSERVE, 16'hFFFF, 1'b0);
    send_item(FUNC_OBSERVE, 16'd40000, 1'b0);
    send_item(FUNC_OBSERVE, 16'h0000, 1'b0);
  endtask

  task automatic test_median_selection();
    drain_results();
    program_regs(16'h0000, 16'hFFFF, 16'h0000, 17'd32768, 7'd4);
    send_item(FUNC_RESTART, 16'h0000, 1'b0);
    send_item(FUNC_OBSERVE, 16'd10, 1'b0);
    send_item(FUNC_OBSERVE, 16'd1, 1'b1);
    send_item(FUNC_OBSERVE, 16'd7, 1'b0);
    send_item(FUNC_OBSERVE, 16'd9, 1'b0);
    send_item(FUNC_OBSERVE, 16'd8, 1'b0);
    send_item(FUNC_OBSERVE, 16'd100, 1'b0);
  endtask

  task automatic test_backpressure();
    drain_results();
    program_regs(16'h0000, 16'hFFFF, SeedFloorRst, AlphaRst, 7'd3);
    send_item(FUNC_RESTART, LevelW'($urandom), 1'b0);
    // The receiver holds off while beats keep coming, so the input side backs up.
    hold_requests++;
    repeat (8) send_item(FUNC_OBSERVE, LevelW'($urandom), 1'b0);
    drain_results();
    repeat (4) send_item(FUNC_OBSERVE, LevelW'($urandom), 1'b0);
  endtask

  task automatic test_random_phases();
    logic [LevelW-1:0] lo;
    logic [LevelW-1:0] hi;
    logic [AlphaW-1:0] alpha;
    int unsigned       roll;
    for (int p = 0; p < 4; p++) begin
      lo = pick_level();
      hi = pick_level();
      // Crossed limits survive in about one phase of four where they occur.
      if (lo > hi && $urandom_range(3) != 0) {lo, hi} = {hi, lo};
      case ($urandom_range(4))
        0: alpha = '0;
        1: alpha = QOne;
        2: alpha = '1;
        default: alpha = AlphaW'($urandom_range(65536));
      endcase
      drain_results();
      program_regs(lo, hi, pick_level(), alpha, CountW'($urandom_range(6)));
      send_item(FUNC_RESTART, LevelW'($urandom), 1'($urandom));
      repeat ($urandom_range(5, 9)) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          send_item(FUNC_RESTART, LevelW'($urandom), 1'($urandom));
        end else if (roll < 20) begin
          send_item(FUNC_OBSERVE, LevelW'($urandom), 1'b1);
        end else if (roll < 60) begin
          send_item(FUNC_OBSERVE, LevelW'($urandom), 1'b0);
        end else begin
          send_item(FUNC_OBSERVE, floor_est + LevelW'($urandom_range(64)) - 16'd32, 1'b0);
        end
      end
    end
  endtask

  // Fills the whole store once, with no idling on either side.
  task automatic test_full_store();
    int unsigned quiet_sent;
    quiet_sent = 0;
    drain_results();
    calm = 1'b1;
    program_regs(LevelW'($urandom_range(1000)), LevelW'($urandom_range(60000, 65535)),
                 pick_level(), AlphaW'($urandom_range(65536)),
                 $urandom_range(1) ? 7'd64 : 7'd127);
    send_item(FUNC_RESTART, LevelW'($urandom), 1'b0);
    while (quiet_sent < StoreDepth + 4) begin
      if ($urandom_range(9) == 0) begin
        send_item(FUNC_OBSERVE, LevelW'($urandom), 1'b1);
      end else begin
        send_item(FUNC_OBSERVE, LevelW'($urandom), 1'b0);
        quiet_sent++;
      end
    end
    drain_results();
    calm = 1'b0;
  endtask

  initial begin : receiver_stall
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 29);
      end
    end
  end

  always @(posedge clk_i) begin
    floor_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected beat: noise_floor %0d, is_calibrated %0b",
               noise_floor_o, is_calibrated_o);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (noise_floor_o !== want.noise_floor) begin
          $error("noise_floor: expected %0d, got %0d", want.noise_floor, noise_floor_o);
          fail_count++;
        end
        if (is_calibrated_o !== want.is_calibrated) begin
          $error("is_calibrated: expected %0b, got %0b", want.is_calibrated, is_calibrated_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    for (int unsigned cycles = 0; cycles < CycleLimit; cycles++) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= CFG_MIN_FLOOR;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    func_i          <= FUNC_OBSERVE;
    frame_rms_i     <= '0;
    speech_active_i <= 1'b0;
    min_floor_q  = MinFloorRst;
    max_floor_q  = MaxFloorRst;
    seed_floor_q = SeedFloorRst;
    ema_alpha_q  = AlphaRst;
    cal_count_q  = CalCountRst;
    frames_held  = 0;
    floor_est    = clamp_level(32'(SeedFloorRst));
    calibrated   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_single_frame_unity_alpha();
    test_alpha_above_one_and_limits();
    test_even_median_alpha_zero();
    test_crossed_limits();
    test_median_selection();
    test_backpressure();
    test_random_phases();
    test_full_store();

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_reports.size() != 0) begin
      $error("%0d expected beats never arrived", pending_reports.size());
      fail_count++;
    end
    $display("Sent %0d beats: %0d restarts, %0d median calibrations, %0d EMA updates, %0d skipped",
             items_sent, restarts_seen, calibrations_seen, ema_updates, speech_skipped);
    $display("Limits crossed and at extremes, alpha 0 to beyond one, counts 0 to 127, %0d-cycle hold",
             HoldCycles);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/nft_pkg.sv
rtl/nft_store.sv
rtl/nft_select.sv
rtl/noise_floor_tracker_top.sv
sim/noise_floor_tracker_top_tb.sv
